@@ hw/rtl/bba_pkg.sv @@
// ----------------------------------------------------------------------------
// bba_pkg
// Shared constants, codes and controller/datapath interface types for the
// bitmap block allocator.
// ----------------------------------------------------------------------------
package bba_pkg;

    // Bitmap geometry; WORD_BITS is a power of two
    localparam int MAP_BITS  = 4096;
    localparam int WORD_BITS = 64;
    localparam int NWORDS    = (MAP_BITS + WORD_BITS - 1) / WORD_BITS;
    localparam int ADDR_W    = (NWORDS > 1) ? $clog2(NWORDS) : 1;
    localparam int BIT_W     = $clog2(WORD_BITS);
    localparam int IDX_W     = ADDR_W + BIT_W;
    localparam int LEN_W     = $clog2(MAP_BITS + 1);

    // Fixed field widths
    localparam int BLK_W     = 32;
    localparam int FREE_W    = 13;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] REG_TOTAL_BLOCKS = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_FIRST_DATA   = CFG_IDX_W'(1);

    localparam logic [BLK_W-1:0] TOTAL_RESET = BLK_W'(4096);
    localparam logic [BLK_W-1:0] FIRST_RESET = '0;

    typedef logic [WORD_BITS-1:0] word_t;

    typedef enum logic [1:0] {
        CMD_QUERY     = 2'd0,
        CMD_MARK_USED = 2'd1,
        CMD_MARK_FREE = 2'd2,
        CMD_ALLOC     = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_RANGE    = 2'd1,
        ST_CONFLICT = 2'd2,
        ST_NOFREE   = 2'd3
    } status_t;

    // Controller to datapath
    typedef struct packed {
        logic capture;
        logic lookup_rd;
        logic access_en;
        logic scan_rd;
        logic alloc_en;
        logic result_load;
    } dp_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic is_alloc;
        logic scan_hit;
        logic scan_miss;
    } dp_stat_t;

endpackage

@@ hw/rtl/bba_ctrl.sv @@
// ----------------------------------------------------------------------------
// bba_ctrl
// Sequencer for the allocator: accepts one transaction, steers the datapath
// through lookup, access or scan, and holds the result until it is taken.
// ----------------------------------------------------------------------------
module bba_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    output logic              out_valid,
    input  logic              out_stall,
    input  bba_pkg::dp_stat_t st,
    output bba_pkg::dp_cmd_t  ctl
);
    import bba_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOOKUP,
        S_ACCESS,
        S_SCAN,
        S_ALLOC,
        S_DONE
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   load;

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;
    assign load      = (state_reg == S_DONE) && (!out_valid_reg || !out_stall);

    always_comb
    begin
        ctl            = '0;
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    ctl.capture = 1'b1;
                    state_next  = S_LOOKUP;
                end
            end
            S_LOOKUP:
            begin
                if (st.is_alloc)
                begin
                    state_next = S_SCAN;
                end
                else
                begin
                    ctl.lookup_rd = 1'b1;
                    state_next    = S_ACCESS;
                end
            end
            S_ACCESS:
            begin
                ctl.access_en = 1'b1;
                state_next    = S_DONE;
            end
            S_SCAN:
            begin
                ctl.scan_rd = 1'b1;
                if (st.scan_hit)
                begin
                    state_next = S_ALLOC;
                end
                else if (st.scan_miss)
                begin
                    state_next = S_DONE;
                end
            end
            S_ALLOC:
            begin
                ctl.alloc_en = 1'b1;
                state_next   = S_DONE;
            end
            S_DONE:
            begin
                if (load)
                begin
                    ctl.result_load = 1'b1;
                    out_valid_next  = 1'b1;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

@@ hw/rtl/bba_datapath.sv @@
// ----------------------------------------------------------------------------
// bba_datapath
// Bitmap memory, configuration registers, range checks, free-bit search,
// used-block counter and the result register.
// ----------------------------------------------------------------------------
module bba_datapath (
    input  logic                            clk,
    input  logic                            rst_n,
    input  bba_pkg::dp_cmd_t                ctl,
    output bba_pkg::dp_stat_t               st,
    input  logic [1:0]                      cmd,
    input  logic [bba_pkg::BLK_W-1:0]       block_id,
    input  logic                            cfg_we,
    input  logic [bba_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [bba_pkg::BLK_W-1:0]       cfg_data,
    output logic [1:0]                      status,
    output logic                            is_free,
    output logic [bba_pkg::BLK_W-1:0]       alloc_block,
    output logic [bba_pkg::FREE_W-1:0]      free_count
);
    import bba_pkg::*;

    // Transaction and configuration
    cmd_t              cmd_reg;
    logic [BLK_W-1:0]  blk_reg;
    logic [BLK_W-1:0]  total_reg;
    logic [BLK_W-1:0]  first_reg;
    logic [LEN_W-1:0]  len_reg;
    logic [LEN_W-1:0]  len_next;
    logic [BLK_W-1:0]  span;

    // Lookup
    logic [BLK_W-1:0]  off_now;
    logic [BLK_W-1:0]  off_reg;
    logic              below_reg;
    logic              above_reg;

    // Memory
    word_t             mem [NWORDS];
    logic [NWORDS-1:0] vld_reg;
    word_t             mem_q_reg;
    logic              vld_q_reg;
    logic [ADDR_W-1:0] q_addr_reg;
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
    word_t             word_rd;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    word_t             wr_data;

    // Scan
    logic [ADDR_W-1:0] scan_addr_reg;
    logic              scan_pend_reg;
    logic [IDX_W-1:0]  base;
    logic              base_out;
    logic              word_full;
    logic              last_word;
    word_t             hit_word_reg;
    logic [ADDR_W-1:0] hit_addr_reg;
    word_t             inv;
    word_t             lowest;
    logic [BIT_W-1:0]  pos;
    logic [IDX_W-1:0]  idx_alloc;
    logic              grant_ok;

    // Access
    logic [BIT_W-1:0]  bit_sel;
    logic              bit_used;
    logic              in_rng;

    // Counter and results
    logic [LEN_W-1:0]  used_reg;
    logic              cnt_inc;
    logic              cnt_dec;
    status_t           res_status_reg;
    status_t           res_status_next;
    logic              res_free_reg;
    logic              res_free_next;
    logic [BLK_W-1:0]  res_alloc_reg;
    logic [BLK_W-1:0]  res_alloc_next;
    logic [LEN_W-1:0]  free_now;
    logic [1:0]        status_reg;
    logic              is_free_reg;
    logic [BLK_W-1:0]  alloc_block_reg;
    logic [FREE_W-1:0] free_count_reg;

    // Data area length, clamped to the bitmap
    assign span = total_reg - first_reg;

    always_comb
    begin
        len_next = '0;
        if (total_reg > first_reg)
        begin
            if (span > BLK_W'(MAP_BITS))
            begin
                len_next = LEN_W'(MAP_BITS);
            end
            else
            begin
                len_next = span[LEN_W-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            total_reg <= TOTAL_RESET;
            first_reg <= FIRST_RESET;
            len_reg   <= LEN_W'(MAP_BITS);
        end
        else
        begin
            len_reg <= len_next;
            if (cfg_we && (cfg_index == REG_TOTAL_BLOCKS))
            begin
                total_reg <= cfg_data;
            end
            if (cfg_we && (cfg_index == REG_FIRST_DATA))
            begin
                first_reg <= cfg_data;
            end
        end
    end

    // Capture and range pre-compute
    assign off_now = blk_reg - first_reg;

    always_ff @(posedge clk)
    begin
        if (ctl.capture)
        begin
            cmd_reg <= cmd_t'(cmd);
            blk_reg <= block_id;
        end
        if (ctl.lookup_rd)
        begin
            off_reg   <= off_now;
            below_reg <= (blk_reg < first_reg);
            above_reg <= (blk_reg >= total_reg);
        end
    end

    // Bitmap memory; a word never written reads as all free
    assign rd_en   = ctl.lookup_rd | ctl.scan_rd;
    assign rd_addr = ctl.lookup_rd ? off_now[IDX_W-1:BIT_W] : scan_addr_reg;
    assign word_rd = vld_q_reg ? mem_q_reg : '0;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            mem_q_reg  <= mem[rd_addr];
            q_addr_reg <= rd_addr;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg   <= '0;
            vld_q_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                vld_reg[wr_addr] <= 1'b1;
            end
            if (rd_en)
            begin
                vld_q_reg <= vld_reg[rd_addr];
            end
        end
    end

    // Scan: one read issued per cycle, the word read last cycle checked
    assign base      = {q_addr_reg, BIT_W'(0)};
    assign base_out  = (BLK_W'(base) >= BLK_W'(len_reg));
    assign word_full = &word_rd;
    assign last_word = (q_addr_reg == ADDR_W'(NWORDS - 1));

    assign st.is_alloc  = (cmd_reg == CMD_ALLOC);
    assign st.scan_miss = ctl.scan_rd && scan_pend_reg && (base_out || (word_full && last_word));
    assign st.scan_hit  = ctl.scan_rd && scan_pend_reg && !base_out && !word_full;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan_addr_reg <= '0;
            scan_pend_reg <= 1'b0;
        end
        else if (ctl.capture)
        begin
            scan_addr_reg <= '0;
            scan_pend_reg <= 1'b0;
        end
        else if (ctl.scan_rd)
        begin
            scan_addr_reg <= scan_addr_reg + ADDR_W'(1);
            scan_pend_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (st.scan_hit)
        begin
            hit_word_reg <= word_rd;
            hit_addr_reg <= q_addr_reg;
        end
    end

    // Lowest clear bit: isolate it, then encode its position
    assign inv    = ~hit_word_reg;
    assign lowest = inv & (~inv + word_t'(1));

    always_comb
    begin
        pos = '0;
        for (int j = 0; j < BIT_W; j++)
        begin
            for (int i = 0; i < WORD_BITS; i++)
            begin
                if (((i >> j) & 1) == 1)
                begin
                    pos[j] = pos[j] | lowest[i];
                end
            end
        end
    end

    assign idx_alloc = {hit_addr_reg, pos};
    assign grant_ok  = (BLK_W'(idx_alloc) < BLK_W'(len_reg));

    // Access
    assign bit_sel  = off_reg[BIT_W-1:0];
    assign bit_used = word_rd[bit_sel];
    assign in_rng   = !below_reg && !above_reg && (off_reg < BLK_W'(len_reg));

    always_comb
    begin
        wr_en           = 1'b0;
        wr_addr         = off_reg[IDX_W-1:BIT_W];
        wr_data         = word_rd;
        cnt_inc         = 1'b0;
        cnt_dec         = 1'b0;
        res_status_next = res_status_reg;
        res_free_next   = res_free_reg;
        res_alloc_next  = res_alloc_reg;
        if (ctl.capture)
        begin
            res_status_next = ST_OK;
            res_free_next   = 1'b0;
            res_alloc_next  = '0;
        end
        else if (ctl.access_en)
        begin
            if (!in_rng)
            begin
                res_status_next = ST_RANGE;
            end
            else
            begin
                case (cmd_reg)
                    CMD_QUERY:
                    begin
                        res_free_next = !bit_used;
                    end
                    CMD_MARK_USED:
                    begin
                        if (bit_used)
                        begin
                            res_status_next = ST_CONFLICT;
                        end
                        else
                        begin
                            wr_en   = 1'b1;
                            wr_data = word_rd | (word_t'(1) << bit_sel);
                            cnt_inc = 1'b1;
                        end
                    end
                    CMD_MARK_FREE:
                    begin
                        if (!bit_used)
                        begin
                            res_status_next = ST_CONFLICT;
                        end
                        else
                        begin
                            wr_en   = 1'b1;
                            wr_data = word_rd & ~(word_t'(1) << bit_sel);
                            cnt_dec = 1'b1;
                        end
                    end
                    default:
                    begin
                        res_status_next = res_status_reg;
                    end
                endcase
            end
        end
        else if (st.scan_miss)
        begin
            res_status_next = ST_NOFREE;
        end
        else if (ctl.alloc_en)
        begin
            if (grant_ok)
            begin
                wr_en          = 1'b1;
                wr_addr        = hit_addr_reg;
                wr_data        = hit_word_reg | lowest;
                cnt_inc        = 1'b1;
                res_alloc_next = first_reg + BLK_W'(idx_alloc);
            end
            else
            begin
                res_status_next = ST_NOFREE;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        res_status_reg <= res_status_next;
        res_free_reg   <= res_free_next;
        res_alloc_reg  <= res_alloc_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg <= '0;
        end
        else if (cnt_inc)
        begin
            used_reg <= used_reg + LEN_W'(1);
        end
        else if (cnt_dec)
        begin
            used_reg <= used_reg - LEN_W'(1);
        end
    end

    // Result register; free count floors at zero
    assign free_now = (len_reg > used_reg) ? (len_reg - used_reg) : '0;

    always_ff @(posedge clk)
    begin
        if (ctl.result_load)
        begin
            status_reg      <= res_status_reg;
            is_free_reg     <= res_free_reg;
            alloc_block_reg <= res_alloc_reg;
            free_count_reg  <= FREE_W'(free_now);
        end
    end

    assign status      = status_reg;
    assign is_free     = is_free_reg;
    assign alloc_block = alloc_block_reg;
    assign free_count  = free_count_reg;

endmodule

@@ hw/rtl/bitmap_block_allocator_unit.sv @@
// ----------------------------------------------------------------------------
// bitmap_block_allocator_unit
// First-fit block allocator over a used/free bitmap with a used-block count.
// ----------------------------------------------------------------------------
// One transaction is worked at a time. Query, mark-used and mark-free take a
// single read-modify-write of one bitmap word. Allocate reads the bitmap
// through its single port, one word per cycle from word 0, and stops at the
// first word with a clear bit or at the end of the data area. A finished
// result waits in an output register while the next transaction is accepted.
// The bitmap reads as all free after reset through per-word valid flags, so
// there is no clearing pass. Configuration writes are always ready; they load
// the configuration registers, from which the data-area length is registered.
module bitmap_block_allocator_unit (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic [1:0]                      cmd,
    input  logic [bba_pkg::BLK_W-1:0]       block_id,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic [1:0]                      status,
    output logic                            is_free,
    output logic [bba_pkg::BLK_W-1:0]       alloc_block,
    output logic [bba_pkg::FREE_W-1:0]      free_count,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [bba_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [bba_pkg::BLK_W-1:0]       cfg_data
);
    import bba_pkg::*;

    dp_cmd_t  ctl;
    dp_stat_t st;

    assign cfg_ready = 1'b1;

    bba_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .st        (st),
        .ctl       (ctl)
    );

    bba_datapath u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctl         (ctl),
        .st          (st),
        .cmd         (cmd),
        .block_id    (block_id),
        .cfg_we      (cfg_valid & cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .status      (status),
        .is_free     (is_free),
        .alloc_block (alloc_block),
        .free_count  (free_count)
    );

endmodule

@@ hw/rtl/bba_checker.sv @@
// ----------------------------------------------------------------------------
// bba_checker
// Port-level checks for the bitmap block allocator, bound to the top level.
// ----------------------------------------------------------------------------
module bba_checker (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    input  logic                            in_stall,
    input  logic                            out_valid,
    input  logic                            out_stall,
    input  logic [1:0]                      status,
    input  logic                            is_free,
    input  logic [bba_pkg::BLK_W-1:0]       alloc_block,
    input  logic [bba_pkg::FREE_W-1:0]      free_count,
    input  logic                            cfg_valid,
    input  logic                            cfg_ready
);
    import bba_pkg::*;

    // Held result stays put while stalled
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(status) && $stable(is_free)
            && $stable(alloc_block) && $stable(free_count))
        else $error("result changed while stalled");

    // An accepted transaction keeps the input side busy while it is worked
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall ##1 in_stall)
        else $error("input accepted too soon after a transaction");

    // A failed allocate grants nothing and reports no query result
    a_nofree: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status == ST_NOFREE) |-> (alloc_block == '0) && !is_free)
        else $error("no-free result carries a grant");

    // Only a successful query reports a free block
    a_query: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && is_free |-> (status == ST_OK) && (alloc_block == '0))
        else $error("free flag with a non-ok status or a grant");

    // Configuration writes are never held off
    a_cfg: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid |-> cfg_ready)
        else $error("configuration write held off");

endmodule

bind bitmap_block_allocator_unit bba_checker u_bba_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .status      (status),
    .is_free     (is_free),
    .alloc_block (alloc_block),
    .free_count  (free_count),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready)
);
